// ----- design/assert_macros.svh -----
// Assertion macros shared by the frame buffer RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- design/fbri_pkg.sv -----
package fbri_pkg;

  // Default geometry of the frame store
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Width of the clipping arithmetic (covers x+w and y+h of any legal item)
  localparam int CALC_W = 10;

  // Item modes
  localparam logic MODE_INVERT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Display link command bytes
  localparam logic [7:0] CMD_PAGE         = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW_MASK = 8'h0F;
  localparam logic [7:0] CMD_COL_HIGH     = 8'h10;
  localparam logic [7:0] BYTE_ZERO        = 8'h00;

  typedef struct packed {
    logic       mode;
    logic [6:0] rect_x;
    logic [5:0] rect_y;
    logic [7:0] rect_width;
    logic [6:0] rect_height;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_byte;
  } result_t;

endpackage

// ----- design/fbri_store.sv -----
module fbri_store #(
  parameter int DEPTH = fbri_pkg::COLUMNS_DEF * fbri_pkg::PAGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/fbri_rmw.sv -----
`include "assert_macros.svh"

module fbri_rmw #(
  parameter int COLUMNS = fbri_pkg::COLUMNS_DEF,
  parameter int PAGES   = fbri_pkg::PAGES_DEF,
  parameter int COL_W   = $clog2(COLUMNS),
  parameter int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1,
  parameter int RW_W    = PG_W + 3,
  parameter int AW      = $clog2(COLUMNS * PAGES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [COL_W-1:0] x_first_in,
  input  logic [COL_W-1:0] x_last_in,
  input  logic [RW_W-1:0]  row_first_in,
  input  logic [RW_W-1:0]  row_last_in,
  output logic             busy,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic [7:0]       rd_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data
);

  localparam int DEPTH = COLUMNS * PAGES;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic [COL_W-1:0] col;
  logic [PG_W-1:0] page;
  logic [COL_W-1:0] x_first;
  logic [COL_W-1:0] x_last;
  logic [PG_W-1:0] pg_first;
  logic [PG_W-1:0] pg_last;
  logic [2:0]      lo_first;
  logic [2:0]      hi_last;
  logic            pend_valid;
  logic [AW-1:0]   pend_addr;
  logic [7:0]      pend_mask;

  logic [2:0]      lo;
  logic [2:0]      hi;
  logic [7:0]      mask_now;
  logic [AW-1:0]   cur_addr;

  // Rows of the rectangle that fall in the current page
  always_comb begin
    lo       = (page == pg_first) ? lo_first : 3'd0;
    hi       = (page == pg_last)  ? hi_last  : 3'd7;
    mask_now = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    cur_addr = AW'(page) * AW'(COLUMNS) + AW'(col);
  end

  // Read now, write back the flipped byte in the next cycle
  assign rd_en   = (state == ST_RUN);
  assign rd_addr = cur_addr;
  assign wr_en   = (state == ST_CLEAR) || pend_valid;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : pend_addr;
  assign wr_data = (state == ST_CLEAR) ? fbri_pkg::BYTE_ZERO : (rd_data ^ pend_mask);
  assign busy    = (state != ST_IDLE) || pend_valid;

  // Sequencer: clearing pass after reset, then column and page walks
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == ST_RUN);
      pend_addr  <= cur_addr;
      pend_mask  <= mask_now;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (go) begin
            x_first  <= x_first_in;
            x_last   <= x_last_in;
            pg_first <= row_first_in[RW_W-1:3];
            pg_last  <= row_last_in[RW_W-1:3];
            lo_first <= row_first_in[2:0];
            hi_last  <= row_last_in[2:0];
            col      <= x_first_in;
            page     <= row_first_in[RW_W-1:3];
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (col == x_last) begin
            col <= x_first;
            if (page == pg_last) begin
              state <= ST_IDLE;
            end else begin
              page <= page + PG_W'(1);
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_rmw_same_entry, clk, rst, wr_en && rd_en && (wr_addr == rd_addr), "read and write hit one entry")
  `ASSERT_PROP(a_rmw_clear_busy, clk, rst, $fell(rst) |-> busy, "clearing pass not running after reset")
  `ASSERT_PROP(a_rmw_go_idle, clk, rst, go |-> !busy, "invert started while busy")

endmodule

// ----- design/fbri_flush.sv -----
`include "assert_macros.svh"

module fbri_flush #(
  parameter int COLUMNS = fbri_pkg::COLUMNS_DEF,
  parameter int PAGES   = fbri_pkg::PAGES_DEF,
  parameter int COL_W   = $clog2(COLUMNS),
  parameter int CNT_W   = $clog2(COLUMNS + 1),
  parameter int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1,
  parameter int AW      = $clog2(COLUMNS * PAGES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [PG_W-1:0]     ld_page,
  input  logic [PG_W-1:0]     ld_final,
  input  logic [COL_W-1:0]    ld_col,
  input  logic [CNT_W-1:0]    ld_count,
  input  logic                tick,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output logic                result_valid,
  output fbri_pkg::result_t   result
);

  localparam int SW = CNT_W + 1;

  typedef enum logic [1:0] {PH_PAGE, PH_COL_LOW, PH_COL_HIGH, PH_DATA} phase_t;

  phase_t           phase;
  logic             pending;
  logic [PG_W-1:0]  page;
  logic [PG_W-1:0]  final_pg;
  logic [COL_W-1:0] start_col;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] sent;
  logic             cmd_valid;
  logic [7:0]       cmd_byte;
  logic             data_wait;
  logic             data_last;

  logic [SW-1:0]    col_sum;
  logic [COL_W-1:0] col;
  logic [CNT_W-1:0] sent_next;

  // Column of the next data byte, held inside the screen
  always_comb begin
    col_sum   = SW'(start_col) + SW'(sent);
    col       = (col_sum >= SW'(COLUMNS)) ? COL_W'(COLUMNS - 1) : COL_W'(col_sum);
    sent_next = sent + CNT_W'(1);
  end

  assign rd_en   = tick && pending && (phase == PH_DATA);
  assign rd_addr = AW'(page) * AW'(COLUMNS) + AW'(col);

  // Command bytes come from a register, data bytes from the store read
  always_comb begin
    result_valid     = cmd_valid || data_wait;
    result.out_byte  = data_wait ? rd_data : cmd_byte;
    result.is_data   = data_wait;
    result.last_byte = data_wait && data_last;
  end

  // Flush sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      phase     <= PH_PAGE;
      page      <= '0;
      final_pg  <= '0;
      start_col <= '0;
      count     <= '0;
      sent      <= '0;
      cmd_valid <= 1'b0;
      data_wait <= 1'b0;
    end else begin
      cmd_valid <= 1'b0;
      data_wait <= 1'b0;
      if (load) begin
        pending   <= 1'b1;
        phase     <= PH_PAGE;
        page      <= ld_page;
        final_pg  <= ld_final;
        start_col <= ld_col;
        count     <= ld_count;
        sent      <= '0;
      end else if (tick && pending) begin
        unique case (phase)
          PH_PAGE: begin
            cmd_byte  <= fbri_pkg::CMD_PAGE + 8'(page);
            cmd_valid <= 1'b1;
            phase     <= PH_COL_LOW;
          end
          PH_COL_LOW: begin
            cmd_byte  <= 8'(start_col) & fbri_pkg::CMD_COL_LOW_MASK;
            cmd_valid <= 1'b1;
            phase     <= PH_COL_HIGH;
          end
          PH_COL_HIGH: begin
            cmd_byte  <= fbri_pkg::CMD_COL_HIGH
                         + ((8'(start_col) >> 4) & fbri_pkg::CMD_COL_LOW_MASK);
            cmd_valid <= 1'b1;
            sent      <= '0;
            phase     <= PH_DATA;
          end
          PH_DATA: begin
            data_wait <= 1'b1;
            data_last <= 1'b0;
            if (sent_next >= count) begin
              if (page >= final_pg) begin
                data_last <= 1'b1;
                pending   <= 1'b0;
              end else begin
                page <= page + PG_W'(1);
              end
              phase <= PH_PAGE;
              sent  <= '0;
            end else begin
              sent <= sent_next;
            end
          end
          default: phase <= PH_PAGE;
        endcase
      end
    end
  end

  `ASSERT_PROP(a_fl_after_tick, clk, rst, result_valid |-> $past(tick), "result without a tick")
  `ASSERT_PROP(a_fl_last_done, clk, rst, (data_wait && data_last) |-> !pending, "flush still pending after last byte")
  `ASSERT_NEVER(a_fl_both, clk, rst, cmd_valid && data_wait, "command and data byte in one cycle")

endmodule

// ----- design/framebuffer_rect_invert_flush.sv -----
// Page-addressed monochrome frame buffer with rectangle invert and paced flush.
// Input channel: an item is taken at a rising edge with start high and busy
// low. Mode invert XOR-flips a clipped rectangle in the store and queues a
// flush of the pages it covers, replacing any flush still queued; an empty or
// off-screen rectangle does nothing. Mode tick emits the next flush byte.
// Result channel: result_valid is high for exactly one cycle, the cycle after
// the tick was taken, carrying one command or data byte; a tick with nothing
// queued gives no result. The receiver cannot stall; results are not held.
// Throughput: ticks may follow every cycle while busy is low. An invert keeps
// busy high while it walks the clipped columns of every covered page and
// until its last write-back, one store entry read-modify-written per cycle
// through the single read and single write port of the store.
// Reset: a sweep over COLUMNS*PAGES entries clears the store (1024 at the
// default geometry), one entry per cycle; busy stays high until it ends.
module framebuffer_rect_invert_flush #(
  parameter int COLUMNS = fbri_pkg::COLUMNS_DEF,
  parameter int PAGES   = fbri_pkg::PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fbri_pkg::item_t   item,
  output logic              result_valid,
  output fbri_pkg::result_t result
);

  localparam int CW    = fbri_pkg::CALC_W;
  localparam int ROWS  = PAGES * 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int CNT_W = $clog2(COLUMNS + 1);
  localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int RW_W  = PG_W + 3;

  logic          accept;
  logic          empty;
  logic          inv_go;
  logic          tick;
  logic [CW-1:0] x_w, y_w, w_w, h_w;
  logic [CW-1:0] x_end_raw, y_end_raw, x_end, y_end;
  logic [CW-1:0] x_last_w, y_last_w, count_w;

  logic          rmw_busy;
  logic          rmw_rd_en;
  logic [AW-1:0] rmw_rd_addr;
  logic          fl_rd_en;
  logic [AW-1:0] fl_rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Decode the transaction and clip the rectangle to the screen
  always_comb begin
    accept    = start && !busy;
    x_w       = CW'(item.rect_x);
    y_w       = CW'(item.rect_y);
    w_w       = CW'(item.rect_width);
    h_w       = CW'(item.rect_height);
    x_end_raw = x_w + w_w;
    y_end_raw = y_w + h_w;
    x_end     = (x_end_raw > CW'(COLUMNS)) ? CW'(COLUMNS) : x_end_raw;
    y_end     = (y_end_raw > CW'(ROWS)) ? CW'(ROWS) : y_end_raw;
    x_last_w  = x_end - CW'(1);
    y_last_w  = y_end - CW'(1);
    count_w   = x_end - x_w;
    empty     = (w_w == '0) || (h_w == '0) || (x_w >= CW'(COLUMNS)) || (y_w >= CW'(ROWS));
    inv_go    = accept && (item.mode == fbri_pkg::MODE_INVERT) && !empty;
    tick      = accept && (item.mode == fbri_pkg::MODE_TICK);
  end

  assign busy = rmw_busy;

  // Share the store read port; the walker and the flush never read together
  assign rd_en   = rmw_rd_en || fl_rd_en;
  assign rd_addr = rmw_rd_en ? rmw_rd_addr : fl_rd_addr;

  fbri_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fbri_rmw #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .COL_W   (COL_W),
    .PG_W    (PG_W),
    .RW_W    (RW_W),
    .AW      (AW)
  ) u_rmw (
    .clk          (clk),
    .rst          (rst),
    .go           (inv_go),
    .x_first_in   (COL_W'(x_w)),
    .x_last_in    (COL_W'(x_last_w)),
    .row_first_in (RW_W'(y_w)),
    .row_last_in  (RW_W'(y_last_w)),
    .busy         (rmw_busy),
    .rd_en        (rmw_rd_en),
    .rd_addr      (rmw_rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  fbri_flush #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .COL_W   (COL_W),
    .CNT_W   (CNT_W),
    .PG_W    (PG_W),
    .AW      (AW)
  ) u_flush (
    .clk          (clk),
    .rst          (rst),
    .load         (inv_go),
    .ld_page      (PG_W'(y_w >> 3)),
    .ld_final     (PG_W'(y_last_w >> 3)),
    .ld_col       (COL_W'(x_w)),
    .ld_count     (CNT_W'(count_w)),
    .tick         (tick),
    .rd_en        (fl_rd_en),
    .rd_addr      (fl_rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- verif/tb_framebuffer_rect_invert_flush.sv -----
module tb_framebuffer_rect_invert_flush;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = fbri_pkg::COLUMNS_DEF;
  localparam int PGS  = fbri_pkg::PAGES_DEF;
  localparam int ROWS = PGS * 8;
  localparam int ITEM_W = $bits(fbri_pkg::item_t);
  localparam int ITEM_TARGET = 580;
  localparam int REPORT_MAX  = 10;

  // Flush emission phases within one page
  typedef enum logic [1:0] {PH_PAGE, PH_COL_LO, PH_COL_HI, PH_DATA} flush_phase_t;

  typedef struct {
    fbri_pkg::item_t it;
    bit              drain;
  } pending_t;

  logic              clk;
  logic              rst;
  logic              start = 1'b0;
  logic              busy;
  fbri_pkg::item_t   item = '0;
  logic              result_valid;
  fbri_pkg::result_t result;

  framebuffer_rect_invert_flush u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the frame store and flush pointer
  logic [7:0]   shadow_fb [PGS][COLS] = '{default: fbri_pkg::BYTE_ZERO};
  bit           flush_on = 1'b0;
  int           page_now = 0;
  int           page_end = 0;
  int           col_start = 0;
  int           col_count = 0;
  int           col_sent = 0;
  flush_phase_t phase = PH_PAGE;

  pending_t          item_queue [$];
  fbri_pkg::result_t link_bytes [$];
  int                n_items;
  int                fault_count = 0;
  bit                item_taken = 1'b0;
  int                gap_left = 0;
  int                burst_left = 0;

  // Flip the clipped rectangle and arm a flush of the pages it touches
  function automatic void apply_invert(fbri_pkg::item_t it);
    int x;
    int y;
    int w;
    int h;
    int x_end;
    int y_end;
    x = int'(it.rect_x);
    y = int'(it.rect_y);
    w = int'(it.rect_width);
    h = int'(it.rect_height);
    if (w == 0 || h == 0 || x >= COLS || y >= ROWS) return;
    x_end = (x + w > COLS) ? COLS : x + w;
    y_end = (y + h > ROWS) ? ROWS : y + h;
    for (int i = x; i < x_end; i++)
      for (int j = y; j < y_end; j++)
        shadow_fb[j >> 3][i][j & 7] = ~shadow_fb[j >> 3][i][j & 7];
    page_now  = y >> 3;
    page_end  = ((y + h - 1) >> 3 > PGS - 1) ? PGS - 1 : (y + h - 1) >> 3;
    col_start = x;
    col_count = x_end - x;
    col_sent  = 0;
    phase     = PH_PAGE;
    flush_on  = 1'b1;
  endfunction

  // Work out the link byte that one tick sends, if any
  function automatic bit predict_link_byte(output fbri_pkg::result_t r);
    int col;
    r = '0;
    if (!flush_on) return 1'b0;
    case (phase)
      PH_PAGE: begin
        r.out_byte = 8'(fbri_pkg::CMD_PAGE + page_now);
        phase = PH_COL_LO;
      end
      PH_COL_LO: begin
        r.out_byte = col_start[7:0] & fbri_pkg::CMD_COL_LOW_MASK;
        phase = PH_COL_HI;
      end
      PH_COL_HI: begin
        r.out_byte = 8'(fbri_pkg::CMD_COL_HIGH + ((col_start >> 4) & 15));
        phase = PH_DATA;
        col_sent = 0;
      end
      default: begin
        col = col_start + col_sent;
        if (col >= COLS) col = COLS - 1;
        r.out_byte = shadow_fb[page_now % PGS][col];
        r.is_data = 1'b1;
        col_sent++;
        if (col_sent >= col_count) begin
          if (page_now >= page_end) begin
            r.last_byte = 1'b1;
            flush_on = 1'b0;
          end else begin
            page_now++;
          end
          phase = PH_PAGE;
          col_sent = 0;
        end
      end
    endcase
    return 1'b1;
  endfunction

  task automatic add_rect(int x, int y, int w, int h);
    pending_t p;
    p.drain = 1'b0;
    p.it.mode = fbri_pkg::MODE_INVERT;
    p.it.rect_x = 7'(x);
    p.it.rect_y = 6'(y);
    p.it.rect_width = 8'(w);
    p.it.rect_height = 7'(h);
    item_queue.push_back(p);
    n_items++;
  endtask

  // Ticks carry random rectangle fields, which the block ignores
  task automatic add_ticks(int n);
    pending_t p;
    p.drain = 1'b0;
    repeat (n) begin
      p.it = ITEM_W'($urandom);
      p.it.mode = fbri_pkg::MODE_TICK;
      item_queue.push_back(p);
      n_items++;
    end
  endtask

  task automatic add_drain();
    pending_t p;
    p.drain = 1'b1;
    p.it = '0;
    item_queue.push_back(p);
  endtask

  // Drive transactions in bursts, holding each until it is taken
  always @(negedge clk) begin : drive_proc
    pending_t head;
    bit       drive;
    drive = 1'b0;
    head.it = '0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (item_queue.size() > 0) begin
        if (item_queue[0].drain) begin
          // hold off until every expected byte has come back
          if (link_bytes.size() == 0) void'(item_queue.pop_front());
        end else begin
          head = item_queue.pop_front();
          drive = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
          end
        end
      end
      start <= drive;
      if (drive) item <= head.it;
    end
  end

  // Check returned bytes, then predict from the transaction taken at this edge
  always @(posedge clk) begin : check_proc
    fbri_pkg::result_t want;
    if (!rst) begin
      if (result_valid) begin
        if (link_bytes.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("unexpected byte: out_byte=%02h is_data=%0d last_byte=%0d",
                     result.out_byte, result.is_data, result.last_byte);
        end else begin
          want = link_bytes.pop_front();
          if (result.out_byte !== want.out_byte || result.is_data !== want.is_data ||
              result.last_byte !== want.last_byte) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("byte mismatch: want %02h/%0d/%0d got %02h/%0d/%0d",
                       want.out_byte, want.is_data, want.last_byte,
                       result.out_byte, result.is_data, result.last_byte);
          end
        end
      end
      if (start && !busy) begin
        if (item.mode == fbri_pkg::MODE_TICK) begin
          if (predict_link_byte(want)) link_bytes.push_back(want);
        end else begin
          apply_invert(item);
        end
      end
    end
    item_taken <= !rst && start && !busy;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stim_proc
    int sel;
    int x;
    int y;
    int w;
    int h;
    int cnt;
    int len;
    int n_ticks;

    rst = 1'b1;
    n_items = 0;

    // Tick with nothing queued, then an empty rectangle
    add_ticks(1);
    add_rect(5, 3, 0, 4);
    // Whole screen, partly flushed, with an empty rectangle in the middle
    add_rect(0, 0, 128, 64);
    add_ticks(3);
    add_rect(40, 8, 9, 0);
    add_ticks(1);
    // Replace the pending flush with one clipped at both edges, run it out
    add_rect(124, 60, 20, 10);
    add_ticks(8);
    add_drain();
    // Bottom right pixel
    add_rect(127, 63, 1, 1);
    add_ticks(4);

    // Random rectangles, mostly small and flushed to the end
    while (n_items < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      x = $urandom_range(0, 127);
      y = $urandom_range(0, 63);
      if (sel < 8) begin
        w = $urandom_range(0, 128);
        h = $urandom_range(0, 64);
      end else if (sel < 16) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 128);
        h = (w == 0) ? $urandom_range(0, 64) : 0;
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 12);
      end
      add_rect(x, y, w, h);
      if (w == 0 || h == 0) begin
        n_ticks = $urandom_range(0, 3);
      end else begin
        cnt = (w > 128 - x) ? 128 - x : w;
        len = ((((y + h - 1) >> 3) > 7 ? 7 : (y + h - 1) >> 3) - (y >> 3) + 1) * (3 + cnt);
        if (len > 60 || $urandom_range(0, 4) == 0)
          n_ticks = $urandom_range(1, (len < 60) ? len : 60);
        else
          n_ticks = len + $urandom_range(0, 2);
      end
      add_ticks(n_ticks);
      if ($urandom_range(0, 15) == 0) add_drain();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Drain the stimulus, the expected bytes, then let the block settle
    while (item_queue.size() != 0 || start) @(posedge clk);
    while (link_bytes.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
